// ===== rtl/npdf_pkg.sv =====
// Package for the nearest point distance field unit.
// Holds sizes, fixed-point widths, the sequencer state type and the point tables.
// No dependencies.
`default_nettype none
package npdf_pkg;

  localparam int unsigned POINTS    = 16;
  localparam int unsigned FIELD_RES = 64;
  localparam int unsigned GRID_RES  = 4;
  localparam int unsigned ONE_Q16   = 65536;

  localparam int unsigned IDX_W   = $clog2(FIELD_RES);
  localparam int unsigned DCNT_W  = $clog2(IDX_W + 1);
  localparam int unsigned COORD_W = 24;
  localparam int unsigned DIFF_W  = COORD_W + 1;
  localparam int unsigned SQ_W    = 2 * DIFF_W;
  localparam int unsigned ROOT_W  = SQ_W / 2;
  localparam int unsigned NUM_W   = 48;
  localparam int unsigned DIST_W  = 17;
  localparam int unsigned IN_DATA_W  = 208;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MAP_PREP,
    ST_MAP_DIV,
    ST_PT_SQ,
    ST_PT_ROOT,
    ST_PT_OUT
  } state_t;

  function automatic logic [COORD_W-1:0] corner_pos(input logic [5:0] idx);
    logic [31:0] v;
    v = (32'(idx) * ONE_Q16) / FIELD_RES;
    return COORD_W'(v);
  endfunction

  function automatic logic [COORD_W-1:0] point_x(input logic [5:0] k, input logic mode);
    logic [31:0] kk;
    logic [31:0] c;
    logic [31:0] v;
    kk = 32'(k);
    c  = kk % GRID_RES;
    if (mode) begin
      v = ((2 * c + 1) * ONE_Q16) / (2 * GRID_RES);
    end else begin
      v = (kk * ONE_Q16) / POINTS;
    end
    return COORD_W'(v);
  endfunction

  function automatic logic [COORD_W-1:0] point_y(input logic [5:0] k, input logic mode);
    logic [31:0] kk;
    logic [31:0] r;
    logic [31:0] v;
    logic [15:0] rev;
    kk  = 32'(k);
    r   = kk / GRID_RES;
    rev = '0;
    for (int b = 0; b < 16; b++) begin
      rev[15-b] = kk[b];
    end
    if (mode) begin
      v = ((2 * r + 1) * ONE_Q16) / (2 * GRID_RES);
    end else begin
      v = 32'(rev);
    end
    return COORD_W'(v);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/npdf_isqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
// Depends on npdf_pkg for the radicand and root widths.
`default_nettype none
module npdf_isqrt (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [npdf_pkg::SQ_W-1:0]  value,
  output logic                            done,
  output logic [npdf_pkg::ROOT_W-1:0]     root
);
  import npdf_pkg::*;

  logic [SQ_W-1:0] v_r, v_nxt;
  logic [SQ_W-1:0] res_r, res_nxt;
  logic [SQ_W-1:0] bit_r, bit_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [SQ_W-1:0] trial;

  always_comb begin
    v_nxt    = v_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = res_r + bit_r;
    if (start) begin
      v_nxt    = value;
      res_nxt  = '0;
      bit_nxt  = SQ_W'(1) << (SQ_W - 2);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_nxt   = v_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign root = res_r[ROOT_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/nearest_point_distance_field_unit.sv =====
// Top level of the nearest point distance field unit.
// Depends on npdf_pkg and npdf_isqrt.
//
// Usage: an item arrives on the in_ stream; in_tuser is the opcode. Opcode 0
// names the field cell directly, opcode 1 maps a position inside a box to a
// cell. For every feature point, in index order, one transfer leaves on the
// out_ stream with the distance from the cell corner to that point; tlast
// marks the final one, which also carries the index of the nearest point.
// out_tuser flags a box of non-positive width or height.
// Timing: an item passes the setup state, for opcode 1 then cell mapping on a
// shared six-step divider, then per point a square state, the shared square
// root unit and an output state that waits until the transfer is taken.
// in_tready is high only while the unit is idle. When the receiver stalls,
// the sequencer holds the pending result until it is taken.
// Reset clears the sequencer, the output valid and the pattern mode register.
`default_nettype none
module nearest_point_distance_field_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // cell_col, cell_row, pos_x, pos_y, box_min_x, box_min_y, box_max_x, box_max_y
  input  wire logic [npdf_pkg::IN_DATA_W-1:0]   in_tdata,
  // opcode
  input  wire logic                             in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // point_index, distance, nearest_index, out_col, out_row
  output logic [npdf_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                  out_tlast,
  // bad_box
  output logic                                  out_tuser,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [2:0]                       cfg_paddr,
  input  wire logic [31:0]                      cfg_pwdata,
  output logic [31:0]                           cfg_prdata,
  output logic                                  cfg_pready
);
  import npdf_pkg::*;

  state_t state_r, state_nxt;
  logic   mode_r;

  logic               op_r, op_nxt;
  logic [5:0]         ccol_r, ccol_nxt, crow_r, crow_nxt;
  logic signed [31:0] posx_r, posx_nxt, posy_r, posy_nxt;
  logic signed [31:0] minx_r, minx_nxt, miny_r, miny_nxt;
  logic signed [31:0] maxx_r, maxx_nxt, maxy_r, maxy_nxt;
  logic signed [32:0] diffx_r, diffx_nxt, diffy_r, diffy_nxt;
  logic signed [32:0] sizex_r, sizex_nxt, sizey_r, sizey_nxt;
  logic               bad_r, bad_nxt;
  logic               ax_r, ax_nxt;
  logic [5:0]         col_r, col_nxt, row_r, row_nxt;
  logic [NUM_W-1:0]   rem_r, rem_nxt, dsh_r, dsh_nxt;
  logic [IDX_W-1:0]   quo_r, quo_nxt;
  logic [DCNT_W-1:0]  dcnt_r, dcnt_nxt;
  logic [5:0]         k_r, k_nxt;
  logic [SQ_W-1:0]    best_r, best_nxt;
  logic [5:0]         near_r, near_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [5:0]         opi_r, opi_nxt, onear_r, onear_nxt;
  logic [DIST_W-1:0]  odist_r, odist_nxt;
  logic               olast_r, olast_nxt;

  logic signed [32:0]       sdiff, ssize;
  logic signed [NUM_W-1:0]  num, ntop;
  logic                     ge;
  logic [5:0]               map_val;
  logic                     map_done;
  logic [COORD_W-1:0]       px, py, cx, cy;
  logic signed [DIFF_W-1:0] dx, dy;
  logic signed [SQ_W-1:0]   sqx, sqy;
  logic [SQ_W-1:0]          sq;
  logic                     root_start, root_done;
  logic [ROOT_W-1:0]        root;
  logic                     is_last;
  logic                     cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {31'd0, mode_r};

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {7'd0, row_r, col_r, onear_r, odist_r, opi_r};
  assign out_tlast  = olast_r;
  assign out_tuser  = bad_r;

  assign is_last = (k_r == 6'(POINTS - 1));

  assign px  = point_x(k_r, mode_r);
  assign py  = point_y(k_r, mode_r);
  assign cx  = corner_pos(col_r);
  assign cy  = corner_pos(row_r);
  assign dx  = $signed({1'b0, cx}) - $signed({1'b0, px});
  assign dy  = $signed({1'b0, cy}) - $signed({1'b0, py});
  assign sqx = dx * dx;
  assign sqy = dy * dy;
  assign sq  = SQ_W'(sqx) + SQ_W'(sqy);
  assign root_start = (state_r == ST_PT_SQ);

  npdf_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .value (sq),
    .done  (root_done),
    .root  (root)
  );

  assign sdiff = ax_r ? diffy_r : diffx_r;
  assign ssize = ax_r ? sizey_r : sizex_r;
  assign num   = NUM_W'(sdiff) * $signed(NUM_W'(FIELD_RES));
  assign ntop  = NUM_W'(ssize) * $signed(NUM_W'(FIELD_RES - 1));
  assign ge    = (rem_r >= dsh_r);

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    ccol_nxt   = ccol_r;
    crow_nxt   = crow_r;
    posx_nxt   = posx_r;
    posy_nxt   = posy_r;
    minx_nxt   = minx_r;
    miny_nxt   = miny_r;
    maxx_nxt   = maxx_r;
    maxy_nxt   = maxy_r;
    diffx_nxt  = diffx_r;
    diffy_nxt  = diffy_r;
    sizex_nxt  = sizex_r;
    sizey_nxt  = sizey_r;
    bad_nxt    = bad_r;
    ax_nxt     = ax_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    rem_nxt    = rem_r;
    dsh_nxt    = dsh_r;
    quo_nxt    = quo_r;
    dcnt_nxt   = dcnt_r;
    k_nxt      = k_r;
    best_nxt   = best_r;
    near_nxt   = near_r;
    ovalid_nxt = ovalid_r;
    opi_nxt    = opi_r;
    odist_nxt  = odist_r;
    onear_nxt  = onear_r;
    olast_nxt  = olast_r;
    map_val    = '0;
    map_done   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          ccol_nxt  = in_tdata[5:0];
          crow_nxt  = in_tdata[11:6];
          posx_nxt  = in_tdata[43:12];
          posy_nxt  = in_tdata[75:44];
          minx_nxt  = in_tdata[107:76];
          miny_nxt  = in_tdata[139:108];
          maxx_nxt  = in_tdata[171:140];
          maxy_nxt  = in_tdata[203:172];
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        diffx_nxt = 33'(posx_r) - 33'(minx_r);
        diffy_nxt = 33'(posy_r) - 33'(miny_r);
        sizex_nxt = 33'(maxx_r) - 33'(minx_r);
        sizey_nxt = 33'(maxy_r) - 33'(miny_r);
        bad_nxt   = op_r & ((sizex_nxt <= 0) | (sizey_nxt <= 0));
        k_nxt     = '0;
        ax_nxt    = 1'b0;
        if (!op_r) begin
          col_nxt   = (ccol_r > 6'(FIELD_RES - 1)) ? 6'(FIELD_RES - 1) : ccol_r;
          row_nxt   = (crow_r > 6'(FIELD_RES - 1)) ? 6'(FIELD_RES - 1) : crow_r;
          state_nxt = ST_PT_SQ;
        end else if (bad_nxt) begin
          col_nxt   = '0;
          row_nxt   = '0;
          state_nxt = ST_PT_SQ;
        end else begin
          state_nxt = ST_MAP_PREP;
        end
      end
      ST_MAP_PREP: begin
        if (num < 0) begin
          map_val  = '0;
          map_done = 1'b1;
        end else if (num >= ntop) begin
          map_val  = 6'(FIELD_RES - 1);
          map_done = 1'b1;
        end else begin
          rem_nxt   = NUM_W'(2 * num + NUM_W'(ssize));
          dsh_nxt   = NUM_W'(2 * NUM_W'(ssize)) << (IDX_W - 1);
          quo_nxt   = '0;
          dcnt_nxt  = '0;
          state_nxt = ST_MAP_DIV;
        end
      end
      ST_MAP_DIV: begin
        if (ge) begin
          rem_nxt = rem_r - dsh_r;
        end
        quo_nxt  = IDX_W'({quo_r, ge});
        dsh_nxt  = dsh_r >> 1;
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DCNT_W'(IDX_W - 1)) begin
          map_val  = 6'(quo_nxt);
          map_done = 1'b1;
        end
      end
      ST_PT_SQ: begin
        if ((k_r == '0) || (sq < best_r)) begin
          best_nxt = sq;
          near_nxt = k_r;
        end
        state_nxt = ST_PT_ROOT;
      end
      ST_PT_ROOT: begin
        if (root_done) begin
          opi_nxt    = k_r;
          odist_nxt  = (root > ROOT_W'(DIST_MAX)) ? DIST_MAX : root[DIST_W-1:0];
          onear_nxt  = is_last ? near_r : 6'd0;
          olast_nxt  = is_last;
          ovalid_nxt = 1'b1;
          state_nxt  = ST_PT_OUT;
        end
      end
      ST_PT_OUT: begin
        if (out_tready) begin
          ovalid_nxt = 1'b0;
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_PT_SQ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (map_done) begin
      if (!ax_r) begin
        col_nxt   = map_val;
        ax_nxt    = 1'b1;
        state_nxt = ST_MAP_PREP;
      end else begin
        row_nxt   = map_val;
        state_nxt = ST_PT_SQ;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    ccol_r  <= ccol_nxt;
    crow_r  <= crow_nxt;
    posx_r  <= posx_nxt;
    posy_r  <= posy_nxt;
    minx_r  <= minx_nxt;
    miny_r  <= miny_nxt;
    maxx_r  <= maxx_nxt;
    maxy_r  <= maxy_nxt;
    diffx_r <= diffx_nxt;
    diffy_r <= diffy_nxt;
    sizex_r <= sizex_nxt;
    sizey_r <= sizey_nxt;
    bad_r   <= bad_nxt;
    ax_r    <= ax_nxt;
    col_r   <= col_nxt;
    row_r   <= row_nxt;
    rem_r   <= rem_nxt;
    dsh_r   <= dsh_nxt;
    quo_r   <= quo_nxt;
    dcnt_r  <= dcnt_nxt;
    k_r     <= k_nxt;
    best_r  <= best_nxt;
    near_r  <= near_nxt;
    opi_r   <= opi_nxt;
    odist_r <= odist_nxt;
    onear_r <= onear_nxt;
    olast_r <= olast_nxt;
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
      mode_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_wr && !cfg_paddr[2]) begin
        mode_r <= cfg_pwdata[0];
      end
    end
  end

endmodule
`default_nettype wire
